// ===== rtl/core/mvt_pkg.sv =====
// shared types, constants and helpers for the 4x4 matrix vertex transform
// no dependencies; imported by every module in rtl/core
package mvt_pkg;

  localparam int unsigned Dim      = 4;
  localparam int unsigned QW       = 32;               // Q16.16 word
  localparam int unsigned FracBits = 16;
  localparam int unsigned ProdW    = 2 * QW;           // full product
  localparam int unsigned TruncW   = ProdW - FracBits; // product after dropping fraction
  localparam int unsigned AccW     = TruncW + 2;       // exact sum of four products
  localparam int unsigned IdxW     = 4;
  localparam int unsigned ColW     = $clog2(Dim);
  localparam int unsigned OpW      = 2;

  localparam logic [OpW-1:0] OpLoad      = 2'd0;
  localparam logic [OpW-1:0] OpTranslate = 2'd1;
  localparam logic [OpW-1:0] OpTransform = 2'd2;

  typedef logic signed [QW-1:0]    comp_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [AccW-1:0]  acc_t;

  localparam comp_t OneQ    = comp_t'(32'sh0001_0000);
  localparam comp_t CompMax = {1'b0, {(QW-1){1'b1}}};
  localparam comp_t CompMin = {1'b1, {(QW-1){1'b0}}};
  localparam acc_t  AccMax  = {{(AccW-QW+1){1'b0}}, {(QW-1){1'b1}}};
  localparam acc_t  AccMin  = {{(AccW-QW+1){1'b1}}, {(QW-1){1'b0}}};

  // one transaction as it walks down the row cells
  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [IdxW-1:0]   idx;
    comp_t             value;
    comp_t [Dim-1:0]   comp;   // x, y, z, w
    acc_t  [Dim-1:0]   acc;    // running column sums
  } item_t;

  function automatic comp_t sat_q(input acc_t s);
    comp_t r;
    if (s > AccMax) begin
      r = CompMax;
    end else if (s < AccMin) begin
      r = CompMin;
    end else begin
      r = s[QW-1:0];
    end
    return r;
  endfunction

  // floor of a Q16.16 product, widened for accumulation
  function automatic acc_t trunc_prod(input prod_t p);
    logic signed [TruncW-1:0] t;
    t = p[ProdW-1:FracBits];
    return acc_t'(t);
  endfunction

endpackage

// ===== rtl/core/mvt_cell.sv =====
// one row cell: holds matrix row Row, multiplies its input component by the row
// and adds the products into the column sums; depends on mvt_pkg
module mvt_cell #(
  parameter int unsigned Row = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mvt_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output mvt_pkg::item_t out_item_o
);
  import mvt_pkg::*;

  localparam logic [ColW-1:0] RowIdx  = ColW'(Row);
  localparam bit              LastRow = (Row == Dim - 1);

  comp_t row_q [Dim];
  prod_t prod_q [Dim];
  prod_t prod_d [Dim];
  item_t a_item_q;
  item_t b_item_q;
  item_t b_item_d;
  logic  a_valid_q;
  logic  b_valid_q;
  logic  a_mul_q;
  logic  mul_en;
  logic  a_ready;
  logic  b_ready;
  logic  take;
  logic  row_hit;

  assign b_ready    = !b_valid_q || out_ready_i;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;
  assign take       = in_valid_i && a_ready;
  assign row_hit    = (in_item_i.idx[IdxW-1:ColW] == RowIdx);

  // the last row takes the translate sum directly; other rows multiply for it
  assign mul_en = (in_item_i.op == OpTransform) ||
                  ((in_item_i.op == OpTranslate) && !LastRow);

  always_comb begin
    for (int c = 0; c < Dim; c++) begin
      prod_d[c] = in_item_i.comp[Row] * row_q[c];
    end
  end

  // every read and write of this row happens as a transaction enters, in order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < Dim; c++) begin
        row_q[c] <= (c == Row) ? OneQ : '0;
      end
    end else if (take) begin
      if (in_item_i.op == OpLoad && row_hit) begin
        row_q[in_item_i.idx[ColW-1:0]] <= in_item_i.value;
      end else if (in_item_i.op == OpTranslate && LastRow) begin
        for (int c = 0; c < Dim; c++) begin
          row_q[c] <= sat_q(in_item_i.acc[c] + acc_t'(row_q[c]));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      a_item_q <= in_item_i;
      a_mul_q  <= mul_en;
      for (int c = 0; c < Dim; c++) begin
        prod_q[c] <= prod_d[c];
      end
    end
    if (b_ready && a_valid_q) begin
      b_item_q <= b_item_d;
    end
  end

  always_comb begin
    b_item_d = a_item_q;
    if (a_mul_q) begin
      for (int c = 0; c < Dim; c++) begin
        b_item_d.acc[c] = a_item_q.acc[c] + trunc_prod(prod_q[c]);
      end
    end
  end

  assign out_valid_o = b_valid_q;
  assign out_item_o  = b_item_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !b_ready |=> a_valid_q && $stable(a_item_q))
    else $error("stage a lost its transaction while blocked");

  load_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && in_item_i.op == OpLoad && row_hit
      |=> row_q[$past(in_item_i.idx[ColW-1:0])] == $past(in_item_i.value))
    else $error("element load did not reach the row");

endmodule

// ===== rtl/core/mvt_sat.sv =====
// output stage: saturates the column sums of transform transactions and holds
// the result until taken; drops other transactions; depends on mvt_pkg
module mvt_sat (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mvt_pkg::item_t                 in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output mvt_pkg::comp_t [mvt_pkg::Dim-1:0] out_comp_o
);
  import mvt_pkg::*;

  logic            out_valid_q;
  comp_t [Dim-1:0] out_comp_q;
  logic            slot_free;
  logic            is_xform;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign is_xform   = (in_item_i.op == OpTransform);
  assign in_ready_o = slot_free || !is_xform;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= in_valid_i && is_xform;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && in_valid_i && is_xform) begin
      for (int c = 0; c < Dim; c++) begin
        out_comp_q[c] <= sat_q(in_item_i.acc[c]);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_comp_o  = out_comp_q;

  rose_from_xform: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_i && is_xform))
    else $error("result appeared without a transform transaction");

endmodule

// ===== rtl/core/matrix4_vertex_transform_unit.sv =====
// top level of the 4x4 matrix vertex transform: a chain of four row cells and
// a saturating output stage; depends on mvt_pkg, mvt_cell and mvt_sat
//
// Usage:
//   Input (in_valid_i / in_stall_o) takes one transaction per unstalled cycle:
//   operation 0 loads one Q16.16 matrix element, 1 applies a translation by
//   (in_x, in_y, in_z) to row 3, 2 transforms the point (in_x..in_w), 3 is a no-op.
//   Only transforms produce a result on the output channel
//   (out_valid_o / out_stall_i), as saturated Q16.16 out_x..out_w.
//   Throughput: one transaction per cycle while unstalled, for every operation,
//   including back-to-back loads, translates and transforms; each cell owns one
//   matrix row and handles every transaction in arrival order, so no hazard
//   stalls arise.
//   Each cell has one multiply stage (four 32x32 multipliers) and one add stage.
//   Reset sets the matrix to identity and empties the pipeline.
//   When the receiver stalls, the result waits in the output register; the
//   chain keeps accepting until its eight stages are full, then in_stall_o rises.
module matrix4_vertex_transform_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mvt_pkg::OpW-1:0]       operation_i,
  input  logic [mvt_pkg::IdxW-1:0]      element_index_i,
  input  mvt_pkg::comp_t                element_value_i,
  input  mvt_pkg::comp_t                in_x_i,
  input  mvt_pkg::comp_t                in_y_i,
  input  mvt_pkg::comp_t                in_z_i,
  input  mvt_pkg::comp_t                in_w_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mvt_pkg::comp_t                out_x_o,
  output mvt_pkg::comp_t                out_y_o,
  output mvt_pkg::comp_t                out_z_o,
  output mvt_pkg::comp_t                out_w_o
);
  import mvt_pkg::*;

  logic            link_valid [Dim+1];
  logic            link_ready [Dim+1];
  item_t           link_item  [Dim+1];
  comp_t [Dim-1:0] out_comp;

  always_comb begin
    link_item[0]         = '0;
    link_item[0].op      = operation_i;
    link_item[0].idx     = element_index_i;
    link_item[0].value   = element_value_i;
    link_item[0].comp[0] = in_x_i;
    link_item[0].comp[1] = in_y_i;
    link_item[0].comp[2] = in_z_i;
    link_item[0].comp[3] = in_w_i;
  end

  assign link_valid[0] = in_valid_i;
  assign in_stall_o    = !link_ready[0];

  for (genvar r = 0; r < Dim; r++) begin : g_row
    mvt_cell #(
      .Row (r)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (link_valid[r]),
      .in_ready_o  (link_ready[r]),
      .in_item_i   (link_item[r]),
      .out_valid_o (link_valid[r+1]),
      .out_ready_i (link_ready[r+1]),
      .out_item_o  (link_item[r+1])
    );
  end

  mvt_sat u_sat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (link_valid[Dim]),
    .in_ready_o  (link_ready[Dim]),
    .in_item_i   (link_item[Dim]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_comp_o  (out_comp)
  );

  assign out_x_o = out_comp[0];
  assign out_y_o = out_comp[1];
  assign out_z_o = out_comp[2];
  assign out_w_o = out_comp[3];

endmodule
